// ===== hdl/pfa_pkg.sv =====
// Shared types and fixed constants for the page-frame allocator.
package pfa_pkg;

    localparam int PAGE_W    = 14;
    localparam int REF_OUT_W = 16;
    localparam int REG_W     = 15;
    localparam int CMD_W     = 3;
    localparam int STAT_W    = 3;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INIT   = 3'd0,
        CMD_ALLOC  = 3'd1,
        CMD_FREE   = 3'd2,
        CMD_INCREF = 3'd3,
        CMD_DECREF = 3'd4
    } cmd_e_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK           = 3'd0,
        STAT_NO_FREE      = 3'd1,
        STAT_REF_NZ       = 3'd2,
        STAT_ALREADY_FREE = 3'd3,
        STAT_UNDERFLOW    = 3'd4,
        STAT_OVERFLOW     = 3'd5,
        STAT_RANGE        = 3'd6
    } stat_e_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAGE_COUNT  = 2'd0,
        CFG_HOLE_FIRST  = 2'd1,
        CFG_HOLE_END    = 2'd2,
        CFG_KERNEL_END  = 2'd3
    } cfg_idx_e_t;

    typedef struct packed {
        stat_e_t                status;
        logic [PAGE_W-1:0]      page_out;
        logic [REF_OUT_W-1:0]   ref_after;
        logic                   zero_fill;
    } res_t;

endpackage

// ===== hdl/pfa_exec.sv =====
// Command decode and read-modify-write logic for one non-init command.
module pfa_exec
    import pfa_pkg::*;
#(
    parameter int AW       = 14,
    parameter int CW       = 15,
    parameter int REF_BITS = 16
)
(
    input  logic [CMD_W-1:0]        cmd,
    input  logic [PAGE_W-1:0]       pg,
    input  logic                    zreq,
    input  logic [REF_BITS+AW:0]    rd_data,
    input  logic [AW-1:0]           head,
    input  logic [CW-1:0]           fcount,
    input  logic [CW-1:0]           active,
    output res_t                    res,
    output logic                    we,
    output logic [AW-1:0]           waddr,
    output logic [REF_BITS+AW:0]    wdata,
    output logic [AW-1:0]           head_next,
    output logic [CW-1:0]           fcount_next
);

    logic                rd_on;
    logic [REF_BITS-1:0] rd_ref;
    logic [AW-1:0]       rd_link;
    logic [REF_BITS-1:0] ref_dec;
    logic [REF_BITS-1:0] ref_inc;
    logic [AW-1:0]       pg_addr;
    logic [AW-1:0]       push_link;
    logic                out_of_range;

    assign rd_on        = rd_data[REF_BITS+AW];
    assign rd_ref       = rd_data[AW +: REF_BITS];
    assign rd_link      = rd_data[AW-1:0];
    assign ref_dec      = rd_ref - REF_BITS'(1);
    assign ref_inc      = rd_ref + REF_BITS'(1);
    assign pg_addr      = AW'(pg);
    assign push_link    = (fcount == '0) ? '0 : head;
    assign out_of_range = (32'(pg) >= 32'(active));

    always_comb
    begin
        res         = '{STAT_OK, pg, '0, 1'b0};
        we          = 1'b0;
        waddr       = pg_addr;
        wdata       = rd_data;
        head_next   = head;
        fcount_next = fcount;
        case (cmd)
            CMD_ALLOC:
            begin
                if (fcount == '0)
                begin
                    res = '{STAT_NO_FREE, '0, '0, 1'b0};
                end
                else
                begin
                    res         = '{STAT_OK, PAGE_W'(head), REF_OUT_W'(rd_ref), zreq};
                    we          = 1'b1;
                    waddr       = head;
                    wdata       = {1'b0, rd_ref, {AW{1'b0}}};
                    fcount_next = fcount - CW'(1);
                    head_next   = (fcount == CW'(1)) ? '0 : rd_link;
                end
            end
            CMD_FREE:
            begin
                if (out_of_range)
                begin
                    res.status = STAT_RANGE;
                end
                else if (rd_ref != '0)
                begin
                    res = '{STAT_REF_NZ, pg, REF_OUT_W'(rd_ref), 1'b0};
                end
                else if (rd_on)
                begin
                    res.status = STAT_ALREADY_FREE;
                end
                else
                begin
                    we          = 1'b1;
                    wdata       = {1'b1, rd_ref, push_link};
                    head_next   = pg_addr;
                    fcount_next = fcount + CW'(1);
                end
            end
            CMD_INCREF:
            begin
                if (out_of_range)
                begin
                    res.status = STAT_RANGE;
                end
                else if (rd_ref == '1)
                begin
                    res = '{STAT_OVERFLOW, pg, REF_OUT_W'(rd_ref), 1'b0};
                end
                else
                begin
                    we    = 1'b1;
                    wdata = {rd_on, ref_inc, rd_link};
                    res   = '{STAT_OK, pg, REF_OUT_W'(ref_inc), 1'b0};
                end
            end
            CMD_DECREF:
            begin
                if (out_of_range)
                begin
                    res.status = STAT_RANGE;
                end
                else if (rd_ref == '0)
                begin
                    res.status = STAT_UNDERFLOW;
                end
                else
                begin
                    we    = 1'b1;
                    wdata = {rd_on, ref_dec, rd_link};
                    res   = '{STAT_OK, pg, REF_OUT_W'(ref_dec), 1'b0};
                    // A count that drops to zero returns the page to the list, unless it is already listed.
                    if (ref_dec == '0)
                    begin
                        if (rd_on)
                        begin
                            res.status = STAT_ALREADY_FREE;
                        end
                        else
                        begin
                            wdata       = {1'b1, ref_dec, push_link};
                            head_next   = pg_addr;
                            fcount_next = fcount + CW'(1);
                        end
                    end
                end
            end
            default:
            begin
                res.status = STAT_RANGE;
            end
        endcase
    end

endmodule

// ===== hdl/page_frame_allocator_refcount_top.sv =====
// Top level of the page-frame allocator: page memory, init walk and sequencing.
// Alloc, free, incref and decref read the page entry from the page memory in the
// accept cycle; the execute state writes it back and registers the result strobe,
// which shows once the block is idle, when a new item may already be accepted.
// Init makes one page memory write per managed page.
// Reset leaves the list empty and no page active; the page memory is not cleared,
// and the result must be taken when strobed since the receiver cannot stall.
module page_frame_allocator_refcount_top
    import pfa_pkg::*;
#(
    parameter int MAX_PAGES = 16384,
    parameter int REF_BITS  = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [CMD_W-1:0]        cmd,
    input  logic [PAGE_W-1:0]       page_number,
    input  logic                    zero_fill_request,
    output logic                    done,
    output logic [STAT_W-1:0]       status,
    output logic [PAGE_W-1:0]       page_out,
    output logic [REF_OUT_W-1:0]    ref_after,
    output logic                    zero_fill,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [REG_W-1:0]        cfg_data
);

    // Page address width, and the width of counters that must hold MAX_PAGES itself.
    localparam int AW = $clog2(MAX_PAGES);
    localparam int CW = $clog2(MAX_PAGES + 1);
    // A page entry holds the on-list flag, the reference count and the free link.
    localparam int EW = 1 + REF_BITS + AW;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_INIT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic             done_reg, done_next;
    logic [AW-1:0]    head_reg, head_next;
    logic [CW-1:0]    fcount_reg, fcount_next;
    logic [CW-1:0]    active_reg, active_next;
    logic [CW-1:0]    idx_reg, idx_next;
    res_t             res_reg, res_next;

    // Configuration registers.
    logic [REG_W-1:0] page_count_reg;
    logic [REG_W-1:0] hole_first_reg;
    logic [REG_W-1:0] hole_end_reg;
    logic [REG_W-1:0] kernel_end_reg;

    // The item being worked on.
    logic [CMD_W-1:0]  cmd_reg;
    logic [PAGE_W-1:0] pg_reg;
    logic              zreq_reg;

    // Page memory and its registered read port.
    logic [EW-1:0]     mem [MAX_PAGES];
    logic [EW-1:0]     rd_data_reg;
    logic [AW-1:0]     rd_addr;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [EW-1:0]     mem_wdata;

    // Outputs of the command logic.
    res_t              ex_res;
    logic              ex_we;
    logic [AW-1:0]     ex_waddr;
    logic [EW-1:0]     ex_wdata;
    logic [AW-1:0]     ex_head_next;
    logic [CW-1:0]     ex_fcount_next;

    logic              accept;
    logic [CW-1:0]     active_clamp;
    logic [31:0]       idx_wide;
    logic              reserved;
    logic [AW-1:0]     init_link;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    // Alloc reads the list head; every other command reads the addressed page.
    assign rd_addr = (cmd == CMD_ALLOC) ? head_reg : AW'(page_number);

    // The number of active pages latched by init is page_count clamped to the memory depth.
    assign active_clamp = (32'(page_count_reg) > 32'(MAX_PAGES)) ?
                          CW'(MAX_PAGES) : CW'(page_count_reg);

    // During the init walk, page 0, the I/O hole and the kernel range stay reserved.
    assign idx_wide = 32'(idx_reg);
    assign reserved = (idx_wide == 32'd0)
                   || (idx_wide >= 32'(hole_first_reg) && idx_wide < 32'(hole_end_reg))
                   || (idx_wide >= 32'(hole_end_reg) && idx_wide < 32'(kernel_end_reg));
    assign init_link = (fcount_reg == '0) ? '0 : head_reg;

    pfa_exec #(
        .AW       (AW),
        .CW       (CW),
        .REF_BITS (REF_BITS)
    ) u_exec (
        .cmd         (cmd_reg),
        .pg          (pg_reg),
        .zreq        (zreq_reg),
        .rd_data     (rd_data_reg),
        .head        (head_reg),
        .fcount      (fcount_reg),
        .active      (active_reg),
        .res         (ex_res),
        .we          (ex_we),
        .waddr       (ex_waddr),
        .wdata       (ex_wdata),
        .head_next   (ex_head_next),
        .fcount_next (ex_fcount_next)
    );

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        head_next   = head_reg;
        fcount_next = fcount_reg;
        active_next = active_reg;
        idx_next    = idx_reg;
        res_next    = res_reg;
        mem_we      = 1'b0;
        mem_waddr   = ex_waddr;
        mem_wdata   = ex_wdata;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == CMD_INIT)
                    begin
                        // Init empties the list before the walk rebuilds it.
                        state_next  = S_INIT;
                        head_next   = '0;
                        fcount_next = '0;
                        active_next = active_clamp;
                        idx_next    = '0;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_EXEC:
            begin
                // The page entry is valid now: write back and post the result.
                mem_we      = ex_we;
                head_next   = ex_head_next;
                fcount_next = ex_fcount_next;
                res_next    = ex_res;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end
            S_INIT:
            begin
                if (idx_reg < active_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = idx_reg[AW-1:0];
                    if (reserved)
                    begin
                        mem_wdata = {1'b0, REF_BITS'(1), {AW{1'b0}}};
                    end
                    else
                    begin
                        // Pages are pushed in ascending order, so the highest ends on top.
                        mem_wdata   = {1'b1, {REF_BITS{1'b0}}, init_link};
                        head_next   = idx_reg[AW-1:0];
                        fcount_next = fcount_reg + CW'(1);
                    end
                    idx_next = idx_reg + CW'(1);
                end
                else
                begin
                    res_next   = '{STAT_OK, '0, '0, 1'b0};
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            done_reg       <= 1'b0;
            head_reg       <= '0;
            fcount_reg     <= '0;
            active_reg     <= '0;
            idx_reg        <= '0;
            page_count_reg <= REG_W'(16384);
            hole_first_reg <= REG_W'(160);
            hole_end_reg   <= REG_W'(256);
            kernel_end_reg <= REG_W'(256);
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            head_reg   <= head_next;
            fcount_reg <= fcount_next;
            active_reg <= active_next;
            idx_reg    <= idx_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PAGE_COUNT: page_count_reg <= cfg_data;
                    CFG_HOLE_FIRST: hole_first_reg <= cfg_data;
                    CFG_HOLE_END:   hole_end_reg   <= cfg_data;
                    CFG_KERNEL_END: kernel_end_reg <= cfg_data;
                    default:        page_count_reg <= page_count_reg;
                endcase
            end
        end
    end

    // Item and result payload registers.
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (accept)
        begin
            cmd_reg  <= cmd;
            pg_reg   <= page_number;
            zreq_reg <= zero_fill_request;
        end
    end

    // Page memory: one write port, one read port with registered data.
    // A write always lands before the next item's read is issued.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (accept)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign done      = done_reg;
    assign status    = res_reg.status;
    assign page_out  = res_reg.page_out;
    assign ref_after = res_reg.ref_after;
    assign zero_fill = res_reg.zero_fill;

endmodule

// ===== hdl/pfa_chk.sv =====
// Port-level checker for the page-frame allocator and its bind statement.
module pfa_chk
    import pfa_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic [CMD_W-1:0]     cmd,
    input logic                 done,
    input logic [STAT_W-1:0]    status,
    input logic                 zero_fill
);

    // A result is only posted once the block is free again.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // Every accepted non-init command produces its result.
    a_cmd_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd != CMD_INIT) |-> ##2 done)
        else $error("command result not delivered on time");

    // Each result is a single-cycle strobe.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // Zero fill is only ever flagged on a successful allocation.
    a_zero_fill_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && zero_fill) |-> (status == STAT_OK))
        else $error("zero fill flagged on a failed command");

    // The block only becomes busy by accepting an item.
    a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a start");

endmodule

bind page_frame_allocator_refcount_top pfa_chk u_pfa_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .status    (status),
    .zero_fill (zero_fill)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the page-frame allocator with reference counts.
module tb;
    import pfa_pkg::*;

    localparam int NUM_PAGES = 16384;
    localparam int unsigned CYCLE_LIMIT = 2000000;
    localparam logic [REF_OUT_W-1:0] REF_LIMIT = '1;

    // Shadow copy of the allocator. Every accepted command is applied here in
    // acceptance order, and the outcome it must produce is queued until the
    // block strobes the matching result.
    class page_ledger;
        logic [PAGE_W-1:0]    link_mem  [NUM_PAGES];
        logic [REF_OUT_W-1:0] count_mem [NUM_PAGES];
        bit                   listed    [NUM_PAGES];
        logic [PAGE_W-1:0]    head;
        bit                   empty;
        int unsigned          n_free;
        int unsigned          n_active;
        int unsigned          reg_pages;
        int unsigned          reg_hole_first;
        int unsigned          reg_hole_end;
        int unsigned          reg_kernel_end;
        res_t                 outcomes_due[$];
        int unsigned          status_seen [8];
        int unsigned          results_checked;
        int unsigned          failures;

        function new();
            head           = '0;
            empty          = 1'b1;
            n_free         = 0;
            n_active       = 0;
            reg_pages      = 16384;
            reg_hole_first = 160;
            reg_hole_end   = 256;
            reg_kernel_end = 256;
            results_checked = 0;
            failures       = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function int unsigned pending();
            return outcomes_due.size();
        endfunction

        function void write_register(cfg_idx_e_t idx, logic [REG_W-1:0] value);
            case (idx)
                CFG_PAGE_COUNT: reg_pages      = 32'(value);
                CFG_HOLE_FIRST: reg_hole_first = 32'(value);
                CFG_HOLE_END:   reg_hole_end   = 32'(value);
                CFG_KERNEL_END: reg_kernel_end = 32'(value);
                default: ;
            endcase
        endfunction

        function void push_free(logic [PAGE_W-1:0] p);
            link_mem[p] = empty ? '0 : head;
            head        = p;
            listed[p]   = 1'b1;
            n_free++;
            empty       = 1'b0;
        endfunction

        // Applies one command to the shadow state and queues its outcome.
        function res_t log_command(logic [CMD_W-1:0] op, logic [PAGE_W-1:0] pg, logic zreq);
            res_t                 r;
            int unsigned          n;
            logic [REF_OUT_W-1:0] cnt;
            logic [PAGE_W-1:0]    p;
            r = '{STAT_OK, '0, '0, 1'b0};
            if (op == CMD_INIT) begin
                n = (reg_pages > NUM_PAGES) ? NUM_PAGES : reg_pages;
                head     = '0;
                empty    = 1'b1;
                n_free   = 0;
                n_active = n;
                for (int i = 0; i < n; i++) begin
                    if (i == 0 || (i >= reg_hole_first && i < reg_hole_end)
                            || (i >= reg_hole_end && i < reg_kernel_end)) begin
                        count_mem[i] = REF_OUT_W'(1);
                        link_mem[i]  = '0;
                        listed[i]    = 1'b0;
                    end
                    else begin
                        count_mem[i] = '0;
                        push_free(PAGE_W'(i));
                    end
                end
            end
            else if (op == CMD_ALLOC) begin
                if (empty || n_free == 0) begin
                    r.status = STAT_NO_FREE;
                end
                else begin
                    p = head;
                    n_free--;
                    if (n_free == 0) begin
                        empty = 1'b1;
                        head  = '0;
                    end
                    else begin
                        head = link_mem[p];
                    end
                    link_mem[p] = '0;
                    listed[p]   = 1'b0;
                    r = '{STAT_OK, p, count_mem[p], zreq};
                end
            end
            else if (op > CMD_DECREF || pg >= n_active) begin
                r = '{STAT_RANGE, pg, '0, 1'b0};
            end
            else begin
                cnt = count_mem[pg];
                r.page_out = pg;
                case (op)
                    CMD_FREE: begin
                        if (cnt != 0) begin
                            r.status    = STAT_REF_NZ;
                            r.ref_after = cnt;
                        end
                        else if (listed[pg]) begin
                            r.status = STAT_ALREADY_FREE;
                        end
                        else begin
                            push_free(pg);
                        end
                    end
                    CMD_INCREF: begin
                        if (cnt == REF_LIMIT) begin
                            r.status = STAT_OVERFLOW;
                        end
                        else begin
                            cnt = cnt + 1'b1;
                            count_mem[pg] = cnt;
                        end
                        r.ref_after = cnt;
                    end
                    default: begin
                        if (cnt == 0) begin
                            r.status = STAT_UNDERFLOW;
                        end
                        else begin
                            cnt = cnt - 1'b1;
                            count_mem[pg] = cnt;
                            r.ref_after   = cnt;
                            if (cnt == 0) begin
                                if (listed[pg]) r.status = STAT_ALREADY_FREE;
                                else push_free(pg);
                            end
                        end
                    end
                endcase
            end
            status_seen[r.status]++;
            outcomes_due.push_back(r);
            return r;
        endfunction

        function void report(string what, res_t want, res_t got);
            failures++;
            if (failures <= 10)
                $display("%0s: expected st %0d pg %0d ref %0d zf %0b, got st %0d pg %0d ref %0d zf %0b",
                         what, want.status, want.page_out, want.ref_after, want.zero_fill,
                         got.status, got.page_out, got.ref_after, got.zero_fill);
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (outcomes_due.size() == 0) begin
                want = '{STAT_OK, '0, '0, 1'b0};
                report("result with no command outstanding", want, got);
                return;
            end
            want = outcomes_due.pop_front();
            results_checked++;
            if (got.status !== want.status || got.page_out !== want.page_out
                    || got.ref_after !== want.ref_after || got.zero_fill !== want.zero_fill)
                report("result mismatch", want, got);
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [CMD_W-1:0]     cmd;
    logic [PAGE_W-1:0]    page_number;
    logic                 zero_fill_request;
    logic                 done;
    logic [STAT_W-1:0]    status;
    logic [PAGE_W-1:0]    page_out;
    logic [REF_OUT_W-1:0] ref_after;
    logic                 zero_fill;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [REG_W-1:0]     cfg_data;

    page_ledger           ledger;
    logic [PAGE_W-1:0]    page_pool[$];   // recently allocated frames, reused as targets
    int unsigned          accepted_items = 0;
    int unsigned          cycles = 0;
    int unsigned          idle_pct = 0;
    int unsigned          cur_pages = 16384;
    int unsigned          layouts = 0;

    page_frame_allocator_refcount_top DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .cmd               (cmd),
        .page_number       (page_number),
        .zero_fill_request (zero_fill_request),
        .done              (done),
        .status            (status),
        .page_out          (page_out),
        .ref_after         (ref_after),
        .zero_fill         (zero_fill),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // The run is stopped here if the block hangs, for instance by never
    // dropping busy or by dropping a result.
    always @(posedge clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Everything is sampled at the rising edge, while the inputs that the
    // stimulus changes at the falling edge are stable. Register writes,
    // accepted items and strobed results all pass through the shadow model in
    // the order in which the block sees them.
    always @(posedge clk) begin
        res_t predicted;
        if (rst_n) begin
            if (cfg_we)
                ledger.write_register(cfg_idx_e_t'(cfg_index), cfg_data);
            if (start && !busy) begin
                predicted = ledger.log_command(cmd, page_number, zero_fill_request);
                accepted_items++;
                if (cmd == CMD_ALLOC && predicted.status == STAT_OK) begin
                    page_pool.push_back(predicted.page_out);
                    if (page_pool.size() > 64) void'(page_pool.pop_front());
                end
            end
            if (done)
                ledger.check_result('{stat_e_t'(status), page_out, ref_after, zero_fill});
        end
    end

    // Presents one item and holds it until the block takes it. Start is left
    // high on return so that back-to-back items need no gap. A random number
    // of idle cycles may come first, according to the current idle setting.
    task automatic issue(input logic [CMD_W-1:0] op, input logic [PAGE_W-1:0] pg,
                         input logic zreq);
        int unsigned seen;
        while ($urandom_range(99) < idle_pct) begin
            start = 1'b0;
            @(negedge clk);
        end
        cmd               = op;
        page_number       = pg;
        zero_fill_request = zreq;
        start             = 1'b1;
        seen              = accepted_items;
        do @(negedge clk); while (accepted_items == seen);
    endtask

    // Stops issuing and waits until every outstanding result has come back.
    // Every command produces a result, so an empty queue and a low busy mean
    // the block is idle.
    task automatic quiesce();
        start = 1'b0;
        while (ledger.pending() != 0 || busy) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_e_t idx, input int unsigned value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = REG_W'(value);
        @(negedge clk);
    endtask

    task automatic set_layout(input int unsigned pages, input int unsigned hole_first,
                              input int unsigned hole_end, input int unsigned kern_end);
        quiesce();
        write_reg(CFG_PAGE_COUNT, pages);
        write_reg(CFG_HOLE_FIRST, hole_first);
        write_reg(CFG_HOLE_END, hole_end);
        write_reg(CFG_KERNEL_END, kern_end);
        cfg_we    = 1'b0;
        cur_pages = pages;
        layouts++;
    endtask

    // Target frames: mostly frames that were handed out recently, so that
    // frees and count changes land on live pages, then any managed frame, and
    // now and then any frame number at all.
    function automatic logic [PAGE_W-1:0] pick_page();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 55 && page_pool.size() != 0)
            return page_pool[$urandom_range(page_pool.size() - 1)];
        if (roll < 88)
            return PAGE_W'($urandom_range(cur_pages - 1));
        return PAGE_W'($urandom_range(NUM_PAGES - 1));
    endfunction

    // Decref is weighted above incref so that counts keep falling back to
    // zero and pages keep cycling through the free list. A re-init is only
    // mixed in while the layout is small, since init walks every page.
    task automatic run_random(input int unsigned count);
        int unsigned      roll;
        logic [CMD_W-1:0] op;
        repeat (count) begin
            roll = $urandom_range(99);
            if (roll < 2 && cur_pages <= 256) op = CMD_INIT;
            else if (roll < 33) op = CMD_ALLOC;
            else if (roll < 53) op = CMD_FREE;
            else if (roll < 70) op = CMD_INCREF;
            else if (roll < 96) op = CMD_DECREF;
            else op = CMD_W'($urandom_range(7, 5));
            issue(op, pick_page(), 1'($urandom_range(1)));
        end
    endtask

    task automatic run_phase(input int unsigned pages, input int unsigned hole_first,
                             input int unsigned hole_end, input int unsigned kern_end,
                             input int unsigned idle, input int unsigned count);
        set_layout(pages, hole_first, hole_end, kern_end);
        idle_pct = idle;
        issue(CMD_INIT, '0, 1'b0);
        run_random(count);
    endtask

    initial begin
        int unsigned pages;
        int unsigned idle_modes [4];
        idle_modes = '{0, 62, 20, 62};
        ledger            = new();
        rst_n             = 1'b0;
        start             = 1'b0;
        cmd               = CMD_INIT;
        page_number       = '0;
        zero_fill_request = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_PAGE_COUNT;
        cfg_data          = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Before any init no page is active: alloc finds nothing and every
        // other command, including an unknown one, is out of range.
        issue(CMD_ALLOC, '0, 1'b1);
        issue(CMD_FREE, 14'd5, 1'b0);
        issue(CMD_INCREF, '0, 1'b0);
        issue(CMD_DECREF, '1, 1'b0);
        issue(3'd7, 14'd10, 1'b1);

        // Eight pages, with page 0, the hole at pages 2 and 3 and the kernel
        // at page 4 reserved. Frames 1, 5, 6 and 7 go on the list, 7 on top.
        set_layout(8, 2, 4, 5);
        issue(CMD_INIT, '0, 1'b0);
        issue(CMD_ALLOC, '0, 1'b1);       // frame 7, flagged for clearing
        issue(CMD_ALLOC, '0, 1'b0);       // frame 6
        issue(CMD_FREE, 14'd7, 1'b0);     // back on the list
        issue(CMD_FREE, 14'd7, 1'b0);     // double free of the list head
        issue(CMD_FREE, 14'd2, 1'b0);     // reserved page still referenced
        issue(CMD_DECREF, 14'd5, 1'b0);   // count already zero
        issue(CMD_INCREF, 14'd5, 1'b0);   // listed page may gain a reference
        issue(CMD_DECREF, 14'd5, 1'b0);   // back to zero while still listed
        issue(CMD_INCREF, 14'd6, 1'b0);
        issue(CMD_DECREF, 14'd6, 1'b0);   // reaches zero and is pushed
        issue(CMD_DECREF, 14'd3, 1'b0);   // releases a reserved hole page
        issue(CMD_FREE, 14'd8, 1'b0);     // first frame past the managed range
        issue(CMD_INCREF, '1, 1'b1);
        issue(3'd5, 14'd1, 1'b0);
        repeat (6) issue(CMD_ALLOC, '0, 1'($urandom_range(1)));   // drains the list
        issue(CMD_INIT, '0, 1'b0);        // a second init starts over
        issue(CMD_ALLOC, '0, 1'b0);

        // Random traffic over a series of layouts, the extremes among them:
        // the reset layout at full size, every page reserved, a single page,
        // and a layout one page short of full size whose register values set the upper bits.
        pages = $urandom_range(48, 2);
        run_phase(pages, $urandom_range(pages + 2), $urandom_range(pages + 4),
                  $urandom_range(pages + 4), 0, 300);
        run_phase(16384, 160, 256, 256, 62, 300);
        run_phase(40, 0, 16384, 16384, 20, 120);
        run_phase(1, 16384, 0, 0, 62, 60);
        run_phase(16383, 10923, 5461, 16383, 0, 100);
        foreach (idle_modes[k]) begin
            pages = $urandom_range(48, 2);
            run_phase(pages, $urandom_range(pages + 2), $urandom_range(pages + 4),
                      $urandom_range(pages + 4), idle_modes[k], 180);
        end

        quiesce();
        repeat (8) @(negedge clk);

        $display("Ran %0d commands over %0d layouts, from one page up to full size.",
                 accepted_items, layouts);
        $display("Checked %0d results: ok %0d, none free %0d, referenced %0d, %0s %0d, %0s %0d %0d %0d",
                 ledger.results_checked, ledger.status_seen[STAT_OK],
                 ledger.status_seen[STAT_NO_FREE], ledger.status_seen[STAT_REF_NZ],
                 "already free", ledger.status_seen[STAT_ALREADY_FREE],
                 "underflow/overflow/range", ledger.status_seen[STAT_UNDERFLOW],
                 ledger.status_seen[STAT_OVERFLOW], ledger.status_seen[STAT_RANGE]);
        if (ledger.failures == 0 && ledger.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
